[sv/ams_pkg.sv]
// ams_pkg: shared types and constants of the adjacency matrix store
// field widths, operation codes, register indexes and the controller/datapath structs
// no dependencies
package ams_pkg;

   // fixed field widths of the request and response words
   localparam int MODE_BITS       = 3;
   localparam int VERTEX_BITS     = 4;
   localparam int WEIGHT_IN_BITS  = 16;
   localparam int OUT_VERTEX_BITS = 3;

   // configuration port widths
   localparam int CFG_INDEX_BITS = 1;
   localparam int CFG_DATA_BITS  = 4;

   // wide enough to hold any stored weight and its negation
   localparam int EXT_BITS = 34;

   // operation codes
   localparam logic [MODE_BITS-1:0] MODE_ADD    = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUERY  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_NEGATE = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_LIST   = 3'd4;

   // register indexes
   localparam logic [CFG_INDEX_BITS-1:0] CSR_IS_DIRECTED  = 1'd0;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_VERTEX_COUNT = 1'd1;

   // register reset values
   localparam logic                   DIRECTED_RESET = 1'b0;
   localparam logic [VERTEX_BITS-1:0] VCOUNT_RESET   = 4'd8;

   // write address select
   typedef enum logic [1:0] {
      WA_REQ    = 2'd0,
      WA_MIRROR = 2'd1,
      WA_SWEEP  = 2'd2
   } wr_addr_sel_type;

   // write data select
   typedef enum logic [1:0] {
      WD_ADD  = 2'd0,
      WD_ZERO = 2'd1,
      WD_NEG  = 2'd2
   } wr_data_sel_type;

   // response word select
   typedef enum logic [2:0] {
      RSP_PLAIN    = 3'd0,
      RSP_BAD      = 3'd1,
      RSP_QUERY    = 3'd2,
      RSP_PEND_MID = 3'd3,
      RSP_FLUSH    = 3'd4
   } rsp_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic            capture;
      logic            rd_en;
      logic            rd_sweep;
      logic            wr_en;
      wr_addr_sel_type wr_addr_sel;
      wr_data_sel_type wr_data_sel;
      logic            cnt_clear;
      logic            cnt_step;
      logic            pend_clear;
      logic            pend_load;
      logic            emit;
      rsp_sel_type     emit_sel;
   } ams_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic                 req_bad;
      logic                 directed;
      logic                 live_zero;
      logic                 sweep_last;
      logic                 rd_nonzero;
      logic                 pend_valid;
      logic                 out_free;
   } ams_status_type;

endpackage

[sv/ams_req_if.sv]
// ams_req_if: request channel of the adjacency matrix store
// valid/ready handshake carrying one request word; depends on ams_pkg
interface ams_req_if;
   import ams_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [MODE_BITS-1:0]        mode;
   logic [VERTEX_BITS-1:0]      src_vertex;
   logic [VERTEX_BITS-1:0]      dst_vertex;
   logic signed [WEIGHT_IN_BITS-1:0] edge_weight;

   modport source (output valid, mode, src_vertex, dst_vertex, edge_weight, input ready);
   modport sink   (input valid, mode, src_vertex, dst_vertex, edge_weight, output ready);

endinterface

[sv/ams_rsp_if.sv]
// ams_rsp_if: response channel of the adjacency matrix store
// valid/ready handshake carrying one response word; depends on ams_pkg
interface ams_rsp_if;
   import ams_pkg::*;

   logic                             valid;
   logic                             ready;
   logic                             bad_vertex;
   logic                             edge_present;
   logic signed [WEIGHT_IN_BITS-1:0] weight_out;
   logic [OUT_VERTEX_BITS-1:0]       from_vertex;
   logic [OUT_VERTEX_BITS-1:0]       to_vertex;
   logic                             last;

   modport source (output valid, bad_vertex, edge_present, weight_out, from_vertex,
                   to_vertex, last, input ready);
   modport sink   (input valid, bad_vertex, edge_present, weight_out, from_vertex,
                   to_vertex, last, output ready);

endinterface

[sv/ams_datapath.sv]
// ams_datapath: weight memory, request and config registers, sweep counters,
// pending list entry and response register; driven by ams_ctrl commands
// depends on ams_pkg
module ams_datapath #(
   parameter int MAX_VERTICES = 8,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ams_pkg::ams_cmd_type                   cmd,
   output ams_pkg::ams_status_type                status,
   input  logic [ams_pkg::MODE_BITS-1:0]          req_mode,
   input  logic [ams_pkg::VERTEX_BITS-1:0]        req_src_vertex,
   input  logic [ams_pkg::VERTEX_BITS-1:0]        req_dst_vertex,
   input  logic signed [ams_pkg::WEIGHT_IN_BITS-1:0] req_edge_weight,
   input  logic                                   csr_write_en,
   input  logic [ams_pkg::CFG_INDEX_BITS-1:0]     csr_index,
   input  logic [ams_pkg::CFG_DATA_BITS-1:0]      csr_wdata,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic                                   rsp_bad_vertex,
   output logic                                   rsp_edge_present,
   output logic signed [ams_pkg::WEIGHT_IN_BITS-1:0] rsp_weight_out,
   output logic [ams_pkg::OUT_VERTEX_BITS-1:0]    rsp_from_vertex,
   output logic [ams_pkg::OUT_VERTEX_BITS-1:0]    rsp_to_vertex,
   output logic                                   rsp_last
);
   import ams_pkg::*;

   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic signed [EXT_BITS-1:0] W_MAX =
      EXT_BITS'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
   localparam logic signed [EXT_BITS-1:0] W_MIN = -W_MAX - EXT_BITS'(1);

   // saturate to the stored weight range
   function automatic logic [WEIGHT_BITS-1:0] clamp_w(input logic signed [EXT_BITS-1:0] v);
      logic signed [EXT_BITS-1:0] c;
      c = v;
      if (v > W_MAX) begin
         c = W_MAX;
      end else if (v < W_MIN) begin
         c = W_MIN;
      end
      return c[WEIGHT_BITS-1:0];
   endfunction

   // row-major table address
   function automatic logic [AW-1:0] addr_of(input logic [VERTEX_BITS-1:0] row,
                                             input logic [VERTEX_BITS-1:0] col);
      return AW'(int'(row) * MAX_VERTICES + int'(col));
   endfunction

   // captured request
   logic [MODE_BITS-1:0]             mode_ff;
   logic [VERTEX_BITS-1:0]           src_ff;
   logic [VERTEX_BITS-1:0]           dst_ff;
   logic signed [WEIGHT_IN_BITS-1:0] weight_ff;

   // configuration registers
   logic                   directed_ff;
   logic [VERTEX_BITS-1:0] vcount_ff;

   // sweep counters
   logic [VERTEX_BITS-1:0] row_ff, row_in;
   logic [VERTEX_BITS-1:0] col_ff, col_in;
   logic [VERTEX_BITS-1:0] col_next;

   // weight memory with per-entry valid bits
   logic [WEIGHT_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]       valid_ff;
   logic [WEIGHT_BITS-1:0] rd_word_ff;
   logic                   rd_valid_ff;

   // pending list entry
   logic                             pend_valid_ff;
   logic signed [WEIGHT_IN_BITS-1:0] pend_weight_ff;
   logic [OUT_VERTEX_BITS-1:0]       pend_row_ff;
   logic [OUT_VERTEX_BITS-1:0]       pend_col_ff;

   // response register
   logic                             rsp_valid_ff;
   logic                             rsp_bad_ff;
   logic                             rsp_present_ff;
   logic signed [WEIGHT_IN_BITS-1:0] rsp_weight_ff;
   logic [OUT_VERTEX_BITS-1:0]       rsp_from_ff;
   logic [OUT_VERTEX_BITS-1:0]       rsp_to_ff;
   logic                             rsp_last_ff;

   logic [VERTEX_BITS-1:0]      live_n;
   logic                        req_bad;
   logic [AW-1:0]               req_addr;
   logic [AW-1:0]               mirror_addr;
   logic [AW-1:0]               sweep_addr;
   logic [AW-1:0]               rd_addr;
   logic [AW-1:0]               wr_addr;
   logic [WEIGHT_BITS-1:0]      wr_data;
   logic signed [WEIGHT_BITS-1:0] rd_value;
   logic signed [EXT_BITS-1:0]  rd_ext;
   logic signed [EXT_BITS-1:0]  add_ext;
   logic                        rd_nonzero;
   logic                        out_free;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_mode;
         src_ff    <= req_src_vertex;
         dst_ff    <= req_dst_vertex;
         weight_ff <= req_edge_weight;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         directed_ff <= DIRECTED_RESET;
         vcount_ff   <= VCOUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IS_DIRECTED:  directed_ff <= csr_wdata[0];
            CSR_VERTEX_COUNT: vcount_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // live vertex count and range check
   assign live_n  = (int'(vcount_ff) > MAX_VERTICES) ? VERTEX_BITS'(MAX_VERTICES) : vcount_ff;
   assign req_bad = (src_ff >= live_n) || (dst_ff >= live_n);

   // addresses
   assign req_addr    = addr_of(src_ff, dst_ff);
   assign mirror_addr = addr_of(dst_ff, src_ff);
   assign sweep_addr  = addr_of(row_ff, col_ff);
   assign rd_addr     = cmd.rd_sweep ? sweep_addr : req_addr;

   always_comb begin
      case (cmd.wr_addr_sel)
         WA_REQ:    wr_addr = req_addr;
         WA_MIRROR: wr_addr = mirror_addr;
         WA_SWEEP:  wr_addr = sweep_addr;
         default:   wr_addr = req_addr;
      endcase
   end

   // read value, zero where never written
   assign rd_value   = rd_valid_ff ? signed'(rd_word_ff) : '0;
   assign rd_ext     = EXT_BITS'(rd_value);
   assign add_ext    = EXT_BITS'(weight_ff);
   assign rd_nonzero = (rd_value != '0);

   // write data
   always_comb begin
      case (cmd.wr_data_sel)
         WD_ADD:  wr_data = clamp_w(add_ext);
         WD_ZERO: wr_data = '0;
         WD_NEG:  wr_data = clamp_w(-rd_ext);
         default: wr_data = '0;
      endcase
   end

   // weight memory
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // row-major sweep counters
   assign col_next = col_ff + VERTEX_BITS'(1);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.cnt_clear) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.cnt_step) begin
         if (col_next == live_n) begin
            col_in = '0;
            row_in = row_ff + VERTEX_BITS'(1);
         end else begin
            col_in = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // pending list entry, held back so the final one can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.pend_clear) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.pend_load) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_weight_ff <= rd_ext[WEIGHT_IN_BITS-1:0];
         pend_row_ff    <= row_ff[OUT_VERTEX_BITS-1:0];
         pend_col_ff    <= col_ff[OUT_VERTEX_BITS-1:0];
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_bad_ff     <= 1'b0;
         rsp_present_ff <= 1'b0;
         rsp_weight_ff  <= '0;
         rsp_from_ff    <= '0;
         rsp_to_ff      <= '0;
         rsp_last_ff    <= 1'b1;
         case (cmd.emit_sel)
            RSP_PLAIN: ;
            RSP_BAD: begin
               rsp_bad_ff <= 1'b1;
            end
            RSP_QUERY: begin
               rsp_present_ff <= rd_nonzero;
               rsp_weight_ff  <= rd_ext[WEIGHT_IN_BITS-1:0];
            end
            RSP_PEND_MID: begin
               rsp_present_ff <= 1'b1;
               rsp_weight_ff  <= pend_weight_ff;
               rsp_from_ff    <= pend_row_ff;
               rsp_to_ff      <= pend_col_ff;
               rsp_last_ff    <= 1'b0;
            end
            RSP_FLUSH: begin
               if (pend_valid_ff) begin
                  rsp_present_ff <= 1'b1;
                  rsp_weight_ff  <= pend_weight_ff;
                  rsp_from_ff    <= pend_row_ff;
                  rsp_to_ff      <= pend_col_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bad_vertex   = rsp_bad_ff;
   assign rsp_edge_present = rsp_present_ff;
   assign rsp_weight_out   = rsp_weight_ff;
   assign rsp_from_vertex  = rsp_from_ff;
   assign rsp_to_vertex    = rsp_to_ff;
   assign rsp_last         = rsp_last_ff;

   // status back to the controller
   always_comb begin
      status            = '0;
      status.mode       = mode_ff;
      status.req_bad    = req_bad;
      status.directed   = directed_ff;
      status.live_zero  = (live_n == '0);
      status.sweep_last = (col_next == live_n) &&
                          ((row_ff + VERTEX_BITS'(1)) == live_n);
      status.rd_nonzero = rd_nonzero;
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   // a new word is loaded only when the response register can take it
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over an untaken word");

   // the sweep never steps beyond the live square
   assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_step |-> (row_ff < live_n) && (col_ff < live_n))
      else $error("sweep counter out of range");

   // a pending entry is only loaded with a nonzero weight, and a held one is sent out as it is replaced
   assert property (@(posedge clock) disable iff (reset)
      cmd.pend_load |-> rd_nonzero && (cmd.emit || !pend_valid_ff))
      else $error("list entry lost or empty entry held");

endmodule

[sv/ams_ctrl.sv]
// ams_ctrl: operation sequencer of the adjacency matrix store
// one-hot state machine issuing ams_cmd_type commands; depends on ams_pkg
module ams_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ams_pkg::ams_status_type status,
   output ams_pkg::ams_cmd_type    cmd
);
   import ams_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EXEC   = 9'b000000010,
      S_MIRROR = 9'b000000100,
      S_QUERY  = 9'b000001000,
      S_NRD    = 9'b000010000,
      S_NWR    = 9'b000100000,
      S_DONE   = 9'b001000000,
      S_LRD    = 9'b010000000,
      S_LCHK   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      flush_ff, flush_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      flush_in  = flush_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture    = 1'b1;
               cmd.cnt_clear  = 1'b1;
               cmd.pend_clear = 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.mode)
               MODE_ADD, MODE_REMOVE: begin
                  if (status.req_bad) begin
                     if (status.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = RSP_BAD;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     cmd.wr_en       = 1'b1;
                     cmd.wr_addr_sel = WA_REQ;
                     cmd.wr_data_sel = (status.mode == MODE_ADD) ? WD_ADD : WD_ZERO;
                     if (!status.directed) begin
                        state_in = S_MIRROR;
                     end else if (status.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = RSP_PLAIN;
                        state_in     = S_IDLE;
                     end
                  end
               end
               MODE_QUERY: begin
                  if (status.req_bad) begin
                     if (status.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = RSP_BAD;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_QUERY;
                  end
               end
               MODE_NEGATE, MODE_LIST: begin
                  if (!status.live_zero) begin
                     state_in = (status.mode == MODE_NEGATE) ? S_NRD : S_LRD;
                  end else if (status.out_free) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = RSP_PLAIN;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  if (status.out_free) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = RSP_PLAIN;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         // mirrored write, repeated harmlessly while the output stalls
         S_MIRROR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = WA_MIRROR;
            cmd.wr_data_sel = (status.mode == MODE_ADD) ? WD_ADD : WD_ZERO;
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = RSP_PLAIN;
               state_in     = S_IDLE;
            end
         end
         S_QUERY: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = RSP_QUERY;
               state_in     = S_IDLE;
            end
         end
         // negate sweep: read then write back each entry
         S_NRD: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sweep = 1'b1;
            state_in     = S_NWR;
         end
         S_NWR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = WA_SWEEP;
            cmd.wr_data_sel = WD_NEG;
            cmd.cnt_step    = 1'b1;
            if (status.sweep_last) begin
               flush_in = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_NRD;
            end
         end
         // final word of negate (plain) or list (held entry with last)
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = flush_ff ? RSP_FLUSH : RSP_PLAIN;
               state_in     = S_IDLE;
            end
         end
         // list sweep
         S_LRD: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sweep = 1'b1;
            state_in     = S_LCHK;
         end
         S_LCHK: begin
            if (!(status.rd_nonzero && status.pend_valid && !status.out_free)) begin
               if (status.rd_nonzero) begin
                  cmd.pend_load = 1'b1;
                  if (status.pend_valid) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = RSP_PEND_MID;
                  end
               end
               cmd.cnt_step = 1'b1;
               if (status.sweep_last) begin
                  flush_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flush_ff <= flush_in;
      end
   end

endmodule

[sv/adjacency_matrix_store_top.sv]
// adjacency_matrix_store_top: top level of the adjacency matrix store
// joins ams_ctrl and ams_datapath to the channel interfaces
// depends on ams_pkg, ams_req_if, ams_rsp_if, ams_ctrl, ams_datapath
//
// Usage: each request word on req_ch names one operation (add, remove, query,
// negate all, list). Every request gives one response word on rsp_ch with
// last set, except a list, which gives one word per stored edge in row-major
// order, last on the final one (one empty word when there are no edges).
// csr_* writes is_directed (index 0) and vertex_count (index 1); the user must write
// them only while idle, the block itself does not enforce it. One request is handled
// at a time; req_ch.ready is high while the block waits. With n live vertices, an
// add or remove writes the entry and, when undirected, then the mirrored entry; a
// query reads the entry; negate and list sweep the n*n live entries in row-major
// order. The single read and single write port of the weight memory set this: a sweep
// reads then writes or checks each entry, and a mirrored write follows the first.
// Response words sit in an output register; when rsp_ch.ready is low the block
// holds its work until the word is taken, losing nothing.
// Reset (synchronous, active high) empties the table at once through per-entry
// valid bits, and sets is_directed to 0 and vertex_count to 8.
module adjacency_matrix_store_top #(
   parameter int MAX_VERTICES = 8,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   ams_req_if.sink                             req_ch,
   ams_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_en,
   input  logic [ams_pkg::CFG_INDEX_BITS-1:0]  csr_index,
   input  logic [ams_pkg::CFG_DATA_BITS-1:0]   csr_wdata
);
   import ams_pkg::*;

   ams_cmd_type    cmd;
   ams_status_type status;
   logic           req_ready;

   // sequencer
   ams_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // table and response datapath
   ams_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_ch.mode),
      .req_src_vertex   (req_ch.src_vertex),
      .req_dst_vertex   (req_ch.dst_vertex),
      .req_edge_weight  (req_ch.edge_weight),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_bad_vertex   (rsp_ch.bad_vertex),
      .rsp_edge_present (rsp_ch.edge_present),
      .rsp_weight_out   (rsp_ch.weight_out),
      .rsp_from_vertex  (rsp_ch.from_vertex),
      .rsp_to_vertex    (rsp_ch.to_vertex),
      .rsp_last         (rsp_ch.last)
   );

endmodule

[tb/sv/tb_adjacency_matrix_store_top.sv]
// tb_adjacency_matrix_store_top: self-checking bench for the adjacency matrix store
// predicts every response word from its own weight table copy and checks each field
// depends on ams_pkg, ams_req_if, ams_rsp_if and adjacency_matrix_store_top
module tb_adjacency_matrix_store_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ams_pkg::*;

   localparam int VERTICES = 8;

   // modes the block does not use
   localparam logic [MODE_BITS-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic signed [WEIGHT_IN_BITS-1:0] WEIGHT_TOP    = 16'sh7FFF;
   localparam logic signed [WEIGHT_IN_BITS-1:0] WEIGHT_BOTTOM = 16'sh8000;

   typedef struct packed {
      logic                             bad_vertex;
      logic                             edge_present;
      logic signed [WEIGHT_IN_BITS-1:0] weight_out;
      logic [OUT_VERTEX_BITS-1:0]       from_vertex;
      logic [OUT_VERTEX_BITS-1:0]       to_vertex;
      logic                             last;
   } rsp_word_type;

   // own copy of the weight table and registers, plus the words still owed
   class matrix_scoreboard;
      logic signed [WEIGHT_IN_BITS-1:0] weights [VERTICES*VERTICES];
      logic                             directed;
      logic [VERTEX_BITS-1:0]           vcount;
      rsp_word_type                     owed_words [$];
      int                               errors;

      function new();
         foreach (weights[i]) weights[i] = '0;
         directed = DIRECTED_RESET;
         vcount   = VCOUNT_RESET;
         errors   = 0;
      endfunction

      function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                 logic [CFG_DATA_BITS-1:0] value);
         if (idx == CSR_IS_DIRECTED) begin
            directed = value[0];
         end else begin
            vcount = value;
         end
      endfunction

      // counts above the table size behave as the table size
      function int live();
         return (vcount > VERTICES) ? VERTICES : int'(vcount);
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      // negating the most negative weight saturates
      function logic signed [WEIGHT_IN_BITS-1:0] negate_sat(logic signed [WEIGHT_IN_BITS-1:0] x);
         if (x == WEIGHT_BOTTOM) return WEIGHT_TOP;
         return -x;
      endfunction

      // work out the response words of one accepted request word
      function void note_request(logic [MODE_BITS-1:0] mode, logic [VERTEX_BITS-1:0] src,
                                 logic [VERTEX_BITS-1:0] dst,
                                 logic signed [WEIGHT_IN_BITS-1:0] wt);
         int           n;
         int           found;
         rsp_word_type w;
         n = live();
         w = '0;
         w.last = 1'b1;
         case (mode)
            MODE_ADD, MODE_REMOVE, MODE_QUERY: begin
               if (src >= n || dst >= n) begin
                  w.bad_vertex = 1'b1;
               end else if (mode == MODE_ADD) begin
                  // input and stored ranges match, so no clamp is needed
                  weights[src*VERTICES + dst] = wt;
                  if (!directed) weights[dst*VERTICES + src] = wt;
               end else if (mode == MODE_REMOVE) begin
                  weights[src*VERTICES + dst] = '0;
                  if (!directed) weights[dst*VERTICES + src] = '0;
               end else begin
                  w.weight_out   = weights[src*VERTICES + dst];
                  w.edge_present = (w.weight_out != 0);
               end
               owed_words.push_back(w);
            end
            MODE_NEGATE: begin
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < n; j++) begin
                     if (weights[i*VERTICES + j] != 0)
                        weights[i*VERTICES + j] = negate_sat(weights[i*VERTICES + j]);
                  end
               end
               owed_words.push_back(w);
            end
            MODE_LIST: begin
               found = 0;
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < n; j++) begin
                     if (weights[i*VERTICES + j] != 0) begin
                        w              = '0;
                        w.edge_present = 1'b1;
                        w.weight_out   = weights[i*VERTICES + j];
                        w.from_vertex  = i[OUT_VERTEX_BITS-1:0];
                        w.to_vertex    = j[OUT_VERTEX_BITS-1:0];
                        owed_words.push_back(w);
                        found++;
                     end
                  end
               end
               if (found == 0) begin
                  w      = '0;
                  w.last = 1'b1;
                  owed_words.push_back(w);
               end else begin
                  // mark the final listed edge
                  w      = owed_words.pop_back();
                  w.last = 1'b1;
                  owed_words.push_back(w);
               end
            end
            default: begin
               owed_words.push_back(w);
            end
         endcase
      endfunction

      task report(string msg);
         $display("%0t ns  error: %s", $realtime, msg);
         errors++;
      endtask

      // compare one accepted response word with the oldest one owed
      task check_response(rsp_word_type got);
         rsp_word_type want;
         if (owed_words.size() == 0) begin
            report("response word arrived with nothing outstanding");
            return;
         end
         want = owed_words.pop_front();
         if (got.bad_vertex !== want.bad_vertex)
            report($sformatf("bad_vertex %0b, want %0b", got.bad_vertex, want.bad_vertex));
         if (got.edge_present !== want.edge_present)
            report($sformatf("edge_present %0b, want %0b", got.edge_present,
                             want.edge_present));
         if (got.weight_out !== want.weight_out)
            report($sformatf("weight_out %0d, want %0d", got.weight_out, want.weight_out));
         if (got.from_vertex !== want.from_vertex)
            report($sformatf("from_vertex %0d, want %0d", got.from_vertex, want.from_vertex));
         if (got.to_vertex !== want.to_vertex)
            report($sformatf("to_vertex %0d, want %0d", got.to_vertex, want.to_vertex));
         if (got.last !== want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CFG_INDEX_BITS-1:0] csr_index;
   logic [CFG_DATA_BITS-1:0]  csr_wdata;
   logic                      gaps_on;
   int                        stall_left;
   matrix_scoreboard          sb;

   ams_req_if req_ch ();
   ams_rsp_if rsp_ch ();

   adjacency_matrix_store_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   initial begin
      #4000000;
      $display("adjacency_matrix_store_top: mismatch");
      $finish;
   end

   // response side: check accepted words, stall in short bursts
   always @(posedge clock) begin : rsp_side
      rsp_word_type observed;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         observed = {rsp_ch.bad_vertex, rsp_ch.edge_present, rsp_ch.weight_out,
                     rsp_ch.from_vertex, rsp_ch.to_vertex, rsp_ch.last};
         sb.check_response(observed);
      end
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // present one request word and hold it until taken
   task automatic send_request(input logic [MODE_BITS-1:0] mode,
                               input logic [VERTEX_BITS-1:0] src,
                               input logic [VERTEX_BITS-1:0] dst,
                               input logic signed [WEIGHT_IN_BITS-1:0] wt);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.src_vertex  <= src;
      req_ch.dst_vertex  <= dst;
      req_ch.edge_weight <= wt;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_request(mode, src, dst, wt);
   endtask

   // stop sending and wait for every owed word
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   // both registers, back to back, only while idle
   task automatic write_config(input logic directed, input logic [CFG_DATA_BITS-1:0] vcount);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_IS_DIRECTED;
      csr_wdata    <= CFG_DATA_BITS'(directed);
      @(posedge clock);
      csr_index    <= CSR_VERTEX_COUNT;
      csr_wdata    <= vcount;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_register(CSR_IS_DIRECTED, CFG_DATA_BITS'(directed));
      sb.set_register(CSR_VERTEX_COUNT, vcount);
   endtask

   // weights biased towards the extremes and small values
   function automatic logic signed [WEIGHT_IN_BITS-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return WEIGHT_TOP;
         1:       return WEIGHT_BOTTOM;
         2:       return '0;
         3:       return WEIGHT_IN_BITS'($urandom_range(1, 9));
         4:       return -WEIGHT_IN_BITS'($urandom_range(1, 9));
         default: return WEIGHT_IN_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [VERTEX_BITS-1:0] pick_vertex(int n);
      if (n == 0) return VERTEX_BITS'($urandom_range(0, 15));
      return VERTEX_BITS'($urandom_range(0, n - 1));
   endfunction

   // mostly in-range edits and queries, with sweeps, spare modes and bad indices
   task automatic run_phase(input int count);
      int                     n;
      int                     r;
      logic [MODE_BITS-1:0]   m;
      logic [VERTEX_BITS-1:0] s;
      logic [VERTEX_BITS-1:0] d;
      n = sb.live();
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         s = pick_vertex(n);
         d = pick_vertex(n);
         if (r < 40)      m = MODE_ADD;
         else if (r < 55) m = MODE_REMOVE;
         else if (r < 78) m = MODE_QUERY;
         else if (r < 83) m = MODE_NEGATE;
         else if (r < 88) m = MODE_LIST;
         else if (r < 92) m = MODE_BITS'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
         else begin
            m = MODE_BITS'($urandom_range(MODE_ADD, MODE_QUERY));
            if ($urandom_range(0, 1) == 0) s = VERTEX_BITS'($urandom_range(n, 15));
            else                           d = VERTEX_BITS'($urandom_range(n, 15));
         end
         if (m >= MODE_NEGATE) begin
            s = VERTEX_BITS'($urandom_range(0, 15));
            d = VERTEX_BITS'($urandom_range(0, 15));
         end
         send_request(m, s, d, pick_weight());
      end
   endtask

   // main sequence
   initial begin
      sb                 = new();
      reset              = 1'b1;
      gaps_on            = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.mode        = '0;
      req_ch.src_vertex  = '0;
      req_ch.dst_vertex  = '0;
      req_ch.edge_weight = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // undirected, full size: empty sweeps, extremes, mirroring, negate
      send_request(MODE_LIST, 0, 0, '0);
      send_request(MODE_NEGATE, 15, 15, '0);
      send_request(MODE_ADD, 0, 0, WEIGHT_TOP);
      send_request(MODE_ADD, 7, 7, WEIGHT_BOTTOM);
      send_request(MODE_ADD, 1, 6, 16'sd1);
      send_request(MODE_ADD, 2, 3, -16'sd1);
      send_request(MODE_QUERY, 6, 1, '0);
      send_request(MODE_NEGATE, 0, 0, '0);
      send_request(MODE_QUERY, 7, 7, '0);
      send_request(MODE_LIST, 9, 4, WEIGHT_BOTTOM);
      send_request(MODE_REMOVE, 6, 1, '0);
      send_request(MODE_QUERY, 1, 6, '0);
      send_request(MODE_ADD, 2, 3, '0);
      // out-of-range indices and spare modes
      send_request(MODE_ADD, 8, 0, 16'sd5);
      send_request(MODE_QUERY, 0, 15, '0);
      send_request(MODE_REMOVE, 15, 15, '0);
      send_request(MODE_SPARE_FIRST, 15, 0, WEIGHT_TOP);
      send_request(MODE_SPARE_LAST, 0, 15, WEIGHT_BOTTOM);

      // directed, three vertices: remove leaves the reverse edge
      drain();
      write_config(1'b1, 4'd3);
      send_request(MODE_ADD, 2, 0, 16'sd5);
      send_request(MODE_QUERY, 0, 2, '0);
      send_request(MODE_ADD, 0, 2, 16'sd7);
      send_request(MODE_REMOVE, 0, 2, '0);
      send_request(MODE_LIST, 0, 0, '0);
      send_request(MODE_ADD, 3, 0, 16'sd1);

      // no vertices: everything is out of range, sweeps are empty
      drain();
      write_config(1'b0, 4'd0);
      send_request(MODE_QUERY, 0, 0, '0);
      send_request(MODE_NEGATE, 0, 0, '0);
      send_request(MODE_LIST, 0, 0, '0);

      // count above the table size acts as full size
      drain();
      write_config(1'b0, 4'd15);
      send_request(MODE_QUERY, 7, 7, '0);
      send_request(MODE_LIST, 0, 0, '0);

      // random phases over several settings, the last one without idling
      for (int p = 0; p < 5; p++) begin
         drain();
         case (p)
            0:       write_config(1'($urandom_range(0, 1)), 4'd8);
            1:       write_config(1'($urandom_range(0, 1)), 4'($urandom_range(2, 7)));
            2:       write_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            3:       write_config(1'($urandom_range(0, 1)), 4'd1);
            default: begin
               gaps_on <= 1'b0;
               write_config(1'($urandom_range(0, 1)), 4'd8);
            end
         endcase
         run_phase(100);
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("adjacency_matrix_store_top: match");
      end else begin
         $display("adjacency_matrix_store_top: mismatch");
      end
      $finish;
   end

endmodule
